@@ rtl/segregated_free_list_allocator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Segregated free-list allocator assertion macros
// Shared concurrent checks, clocked on clock and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define SFLA_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfla: same-cycle check failed");

// next-cycle implication
`define SFLA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfla: next-cycle check failed");

`endif

@@ rtl/sfla_pkg.sv @@
// ----------------------------------------------------------------------------
// Segregated free-list allocator package
// Field widths, function and status codes, defaults and the command bundle.
// ----------------------------------------------------------------------------
package sfla_pkg;

   localparam int FUNC_W     = 2;
   localparam int CLASS_W    = 4;
   localparam int ADDR_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 15;
   localparam int TOTAL_W    = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int HEAP_WORDS_DEF   = 16384;
   localparam int MIN_POW_DEF      = 4;
   localparam int MAX_POW_DEF      = 16;
   localparam int HEADER_BYTES_DEF = 8;

   localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = 32'h0000_0000;
   localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'h0001_0000;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CLASS = 2'd2;

   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_LIMIT = 1'b1;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic execute;
   } sfla_cmd_type;

endpackage

@@ rtl/sfla_ctrl.sv @@
// ----------------------------------------------------------------------------
// Segregated free-list allocator controller
// Sequences capture, memory lookup and update, and owns the handshakes.
// ----------------------------------------------------------------------------
`include "segregated_free_list_allocator_unit_macros.svh"

module sfla_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sfla_pkg::sfla_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      in_exec;

   assign in_exec     = (state_ff == ST_EXEC);
   assign cmd.capture = req_valid && req_ready_ff;
   assign cmd.lookup  = (state_ff == ST_LOOKUP);
   assign cmd.execute = in_exec && (!rsp_valid_ff || rsp_ready);

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.execute) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd.capture) begin
                  state_ff     <= ST_LOOKUP;
                  req_ready_ff <= 1'b0;
               end else begin
                  req_ready_ff <= 1'b1;
               end
            end
            ST_LOOKUP: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (cmd.execute) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b0;
            end
         endcase
      end
   end

   `SFLA_ASSERT_NEXT(a_accept_lookup, cmd.capture, state_ff == ST_LOOKUP)
   `SFLA_ASSERT_NEXT(a_exec_result, cmd.execute, rsp_valid_ff && req_ready_ff)
   `SFLA_ASSERT_NEXT(a_hold_result, in_exec && rsp_valid_ff && !rsp_ready, in_exec && rsp_valid_ff)
   `SFLA_ASSERT_IMPLY(a_ready_idle, req_ready_ff, state_ff == ST_IDLE)

endmodule

@@ rtl/sfla_dpath.sv @@
// ----------------------------------------------------------------------------
// Segregated free-list allocator datapath
// Registers, list heads and counts, link and tag memories, result register.
// ----------------------------------------------------------------------------
`include "segregated_free_list_allocator_unit_macros.svh"

module sfla_dpath #(
   parameter int HEAP_WORDS   = sfla_pkg::HEAP_WORDS_DEF,
   parameter int MIN_POW      = sfla_pkg::MIN_POW_DEF,
   parameter int MAX_POW      = sfla_pkg::MAX_POW_DEF,
   parameter int HEADER_BYTES = sfla_pkg::HEADER_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sfla_pkg::sfla_cmd_type            cmd,
   input  logic [sfla_pkg::FUNC_W-1:0]       req_func,
   input  logic [sfla_pkg::CLASS_W-1:0]      req_size_class,
   input  logic [sfla_pkg::ADDR_W-1:0]       req_block_address,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sfla_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sfla_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sfla_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic [sfla_pkg::ADDR_W-1:0]       rsp_granted_address,
   output logic [sfla_pkg::STATUS_W-1:0]     rsp_status,
   output logic [sfla_pkg::COUNT_W-1:0]      rsp_class_free_count,
   output logic [sfla_pkg::COUNT_W-1:0]      rsp_live_count,
   output logic [sfla_pkg::TOTAL_W-1:0]      rsp_total_count,
   output logic [sfla_pkg::ADDR_W-1:0]       rsp_free_bytes
);

   localparam int NCLASS = MAX_POW - MIN_POW + 1;
   localparam int SLOT_W = $clog2(HEAP_WORDS);
   localparam int CIDX_W = (NCLASS > 1) ? $clog2(NCLASS) : 1;
   localparam int AW     = sfla_pkg::ADDR_W;
   localparam int SUM_W  = AW + 1;
   localparam int CW     = sfla_pkg::COUNT_W;

   logic [AW-1:0]                   heap_base_ff;
   logic [AW-1:0]                   heap_limit_ff;
   logic [AW-1:0]                   bump_ff;
   logic [AW-1:0]                   heads_ff [NCLASS];
   logic [CW-1:0]                   counts_ff [NCLASS];
   logic [CW-1:0]                   live_ff;
   logic [sfla_pkg::TOTAL_W-1:0]    total_ff;

   logic [sfla_pkg::FUNC_W-1:0]     func_ff;
   logic [sfla_pkg::CLASS_W-1:0]    cls_ff;
   logic [AW-1:0]                   addr_ff;
   logic [SLOT_W-1:0]               slot_ff;

   logic [AW-1:0]                   link_mem [HEAP_WORDS];
   logic [sfla_pkg::CLASS_W-1:0]    tag_mem [HEAP_WORDS];
   logic [AW-1:0]                   link_rd_ff;
   logic [sfla_pkg::CLASS_W-1:0]    tag_rd_ff;

   logic [AW-1:0]                   granted_ff;
   logic [sfla_pkg::STATUS_W-1:0]   status_ff;
   logic [CW-1:0]                   fcount_ff;
   logic [AW-1:0]                   free_bytes_ff;

   logic                            csr_write;
   logic                            is_free;
   logic                            cls_ok;
   logic [CIDX_W-1:0]               cidx;
   logic [AW-1:0]                   pick_addr;
   logic [AW-1:0]                   offset;
   logic [SLOT_W-1:0]               lookup_slot;

   logic                            tag_ok;
   logic                            class_ok;
   logic [CIDX_W-1:0]               kidx;
   logic [AW-1:0]                   head_k;
   logic [CW-1:0]                   count_k;
   logic                            pop;
   logic [SUM_W-1:0]                size;
   logic [SUM_W-1:0]                bump_end;
   logic                            fits;

   logic [AW-1:0]                   granted_in;
   logic [sfla_pkg::STATUS_W-1:0]   status_in;
   logic [CW-1:0]                   fcount_in;
   logic                            head_we;
   logic [AW-1:0]                   head_in;
   logic [CW-1:0]                   count_in;
   logic                            bump_we;
   logic [AW-1:0]                   bump_in;
   logic                            tag_we;
   logic                            link_we;
   logic                            alloc_ok;
   logic [CW-1:0]                   live_in;
   logic [sfla_pkg::TOTAL_W-1:0]    total_in;

   // configuration port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == sfla_pkg::REG_HEAP_LIMIT) ? heap_limit_ff : heap_base_ff;

   // lookup: pick the slot to read
   assign is_free     = (func_ff == sfla_pkg::FUNC_FREE);
   assign cls_ok      = 32'(cls_ff) < NCLASS;
   assign cidx        = cls_ok ? CIDX_W'(cls_ff) : '0;
   assign pick_addr   = is_free ? addr_ff :
                        ((counts_ff[cidx] != '0) ? heads_ff[cidx] : bump_ff);
   assign offset      = pick_addr - heap_base_ff;
   assign lookup_slot = offset[SLOT_W+1:2];

   // execute
   assign tag_ok   = 32'(tag_rd_ff) < NCLASS;
   assign class_ok = is_free ? tag_ok : cls_ok;
   assign kidx     = class_ok ? (is_free ? CIDX_W'(tag_rd_ff) : CIDX_W'(cls_ff)) : '0;
   assign head_k   = heads_ff[kidx];
   assign count_k  = counts_ff[kidx];
   assign pop      = (count_k != '0);
   assign size     = (SUM_W'(1) << (int'(cls_ff) + MIN_POW)) + SUM_W'(HEADER_BYTES);
   assign bump_end = {1'b0, bump_ff} + size;
   assign fits     = (bump_end <= {1'b0, heap_limit_ff});

   always_comb begin
      granted_in = '0;
      status_in  = sfla_pkg::STATUS_OK;
      fcount_in  = '0;
      head_we    = 1'b0;
      head_in    = head_k;
      count_in   = count_k;
      bump_we    = 1'b0;
      tag_we     = 1'b0;
      link_we    = 1'b0;
      alloc_ok   = 1'b0;
      case (func_ff)
         sfla_pkg::FUNC_ALLOC: begin
            if (!cls_ok) begin
               status_in = sfla_pkg::STATUS_BAD_CLASS;
            end else if (pop) begin
               granted_in = head_k;
               head_we    = 1'b1;
               head_in    = link_rd_ff;
               count_in   = count_k - CW'(1);
               alloc_ok   = 1'b1;
               fcount_in  = count_k - CW'(1);
            end else if (fits) begin
               granted_in = bump_ff;
               bump_we    = 1'b1;
               alloc_ok   = 1'b1;
               fcount_in  = count_k;
            end else begin
               status_in = sfla_pkg::STATUS_EXHAUSTED;
               fcount_in = count_k;
            end
            tag_we = alloc_ok;
         end
         sfla_pkg::FUNC_FREE: begin
            if (!tag_ok) begin
               status_in = sfla_pkg::STATUS_BAD_CLASS;
            end else begin
               link_we   = 1'b1;
               head_we   = 1'b1;
               head_in   = addr_ff;
               count_in  = count_k + CW'(1);
               fcount_in = count_k + CW'(1);
            end
         end
         default: begin
            if (!cls_ok) begin
               status_in = sfla_pkg::STATUS_BAD_CLASS;
            end else begin
               fcount_in = count_k;
            end
         end
      endcase
   end

   assign bump_in  = bump_we ? bump_end[AW-1:0] : bump_ff;
   assign live_in  = alloc_ok ? live_ff + CW'(1) :
                     (link_we ? live_ff - CW'(1) : live_ff);
   assign total_in = alloc_ok ? total_ff + sfla_pkg::TOTAL_W'(1) : total_ff;

   // allocator state
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= sfla_pkg::HEAP_BASE_RESET;
         heap_limit_ff <= sfla_pkg::HEAP_LIMIT_RESET;
         bump_ff       <= sfla_pkg::HEAP_BASE_RESET;
         live_ff       <= '0;
         total_ff      <= '0;
         for (int i = 0; i < NCLASS; i++) begin
            heads_ff[i]  <= '0;
            counts_ff[i] <= '0;
         end
      end else if (csr_write) begin
         if (csr_paddr[2] == sfla_pkg::REG_HEAP_BASE) begin
            heap_base_ff <= csr_pwdata;
            bump_ff      <= csr_pwdata;
         end else begin
            heap_limit_ff <= csr_pwdata;
         end
      end else if (cmd.execute) begin
         bump_ff  <= bump_in;
         live_ff  <= live_in;
         total_ff <= total_in;
         if (head_we) begin
            heads_ff[kidx]  <= head_in;
            counts_ff[kidx] <= count_in;
         end
      end
   end

   // request capture and result register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         cls_ff  <= req_size_class;
         addr_ff <= req_block_address;
      end
      if (cmd.lookup) begin
         slot_ff <= lookup_slot;
      end
      if (cmd.execute) begin
         granted_ff    <= granted_in;
         status_ff     <= status_in;
         fcount_ff     <= fcount_in;
         free_bytes_ff <= heap_limit_ff - bump_in;
      end
   end

   // link and tag memories
   always_ff @(posedge clock) begin
      if (cmd.execute && link_we) begin
         link_mem[slot_ff] <= head_k;
      end
      if (cmd.lookup) begin
         link_rd_ff <= link_mem[lookup_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && tag_we) begin
         tag_mem[slot_ff] <= cls_ff;
      end
      if (cmd.lookup) begin
         tag_rd_ff <= tag_mem[lookup_slot];
      end
   end

   assign rsp_granted_address  = granted_ff;
   assign rsp_status           = status_ff;
   assign rsp_class_free_count = fcount_ff;
   assign rsp_live_count       = live_ff;
   assign rsp_total_count      = total_ff;
   assign rsp_free_bytes       = free_bytes_ff;

   `SFLA_ASSERT_NEXT(a_total_step, cmd.execute && alloc_ok, total_ff == $past(total_ff) + 32'd1)
   `SFLA_ASSERT_NEXT(a_grant_zero, cmd.execute && !alloc_ok, rsp_granted_address == '0)

endmodule

@@ rtl/segregated_free_list_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Segregated free-list allocator unit
// Each request goes through accept, a registered read of the link and tag
// memories, then the list update and result. A result not yet taken holds
// the unit in its last step. A new request may be taken once a result is
// registered. The link and tag memories have HEAP_WORDS entries (a power of
// two) with no clearing pass; list heads and counts reset at once.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_unit #(
   parameter int HEAP_WORDS   = sfla_pkg::HEAP_WORDS_DEF,
   parameter int MIN_POW      = sfla_pkg::MIN_POW_DEF,
   parameter int MAX_POW      = sfla_pkg::MAX_POW_DEF,
   parameter int HEADER_BYTES = sfla_pkg::HEADER_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sfla_pkg::FUNC_W-1:0]       req_func,
   input  logic [sfla_pkg::CLASS_W-1:0]      req_size_class,
   input  logic [sfla_pkg::ADDR_W-1:0]       req_block_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sfla_pkg::ADDR_W-1:0]       rsp_granted_address,
   output logic [sfla_pkg::STATUS_W-1:0]     rsp_status,
   output logic [sfla_pkg::COUNT_W-1:0]      rsp_class_free_count,
   output logic [sfla_pkg::COUNT_W-1:0]      rsp_live_count,
   output logic [sfla_pkg::TOTAL_W-1:0]      rsp_total_count,
   output logic [sfla_pkg::ADDR_W-1:0]       rsp_free_bytes,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sfla_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sfla_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sfla_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   sfla_pkg::sfla_cmd_type cmd;

   assign csr_pready = 1'b1;

   sfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sfla_dpath #(
      .HEAP_WORDS   (HEAP_WORDS),
      .MIN_POW      (MIN_POW),
      .MAX_POW      (MAX_POW),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_func             (req_func),
      .req_size_class       (req_size_class),
      .req_block_address    (req_block_address),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .rsp_granted_address  (rsp_granted_address),
      .rsp_status           (rsp_status),
      .rsp_class_free_count (rsp_class_free_count),
      .rsp_live_count       (rsp_live_count),
      .rsp_total_count      (rsp_total_count),
      .rsp_free_bytes       (rsp_free_bytes)
   );

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Segregated free-list allocator testbench
// Drives allocate, free and query requests through the valid/ready request
// channel, checks every response field against an in-bench allocator model,
// and moves the heap window through several base/limit settings over APB.
// ----------------------------------------------------------------------------
module tb;

   localparam int WORDS      = sfla_pkg::HEAP_WORDS_DEF;
   localparam int NCLASS     = sfla_pkg::MAX_POW_DEF - sfla_pkg::MIN_POW_DEF + 1;
   localparam int IDLE_LIMIT = 2000;
   localparam logic [sfla_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

   typedef struct packed {
      logic [sfla_pkg::FUNC_W-1:0]  func;
      logic [sfla_pkg::CLASS_W-1:0] cls;
      logic [sfla_pkg::ADDR_W-1:0]  addr;
   } alloc_req_type;

   typedef struct packed {
      logic [sfla_pkg::ADDR_W-1:0]   granted;
      logic [sfla_pkg::STATUS_W-1:0] status;
      logic [sfla_pkg::COUNT_W-1:0]  fcount;
      logic [sfla_pkg::COUNT_W-1:0]  live;
      logic [sfla_pkg::TOTAL_W-1:0]  total;
      logic [sfla_pkg::ADDR_W-1:0]   free_bytes;
   } alloc_rsp_type;

   typedef struct packed {
      alloc_req_type rq;
      bit            typed;
      alloc_rsp_type want;
   } stim_row_type;

   typedef struct packed {
      logic [sfla_pkg::ADDR_W-1:0] base;
      logic [sfla_pkg::ADDR_W-1:0] limit;
      int                          items;
      bit                          steady;
   } heap_setting_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [sfla_pkg::FUNC_W-1:0]     req_func = '0;
   logic [sfla_pkg::CLASS_W-1:0]    req_size_class = '0;
   logic [sfla_pkg::ADDR_W-1:0]     req_block_address = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [sfla_pkg::ADDR_W-1:0]     rsp_granted_address;
   logic [sfla_pkg::STATUS_W-1:0]   rsp_status;
   logic [sfla_pkg::COUNT_W-1:0]    rsp_class_free_count;
   logic [sfla_pkg::COUNT_W-1:0]    rsp_live_count;
   logic [sfla_pkg::TOTAL_W-1:0]    rsp_total_count;
   logic [sfla_pkg::ADDR_W-1:0]     rsp_free_bytes;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [sfla_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [sfla_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [sfla_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // allocator model state
   bit [31:0] cfg_base  = sfla_pkg::HEAP_BASE_RESET;
   bit [31:0] cfg_limit = sfla_pkg::HEAP_LIMIT_RESET;
   bit [31:0] bump      = sfla_pkg::HEAP_BASE_RESET;
   bit [31:0] class_head [NCLASS];
   bit [14:0] class_len  [NCLASS];
   bit [31:0] link_mem   [WORDS];
   bit [3:0]  tag_mem    [WORDS];
   bit        link_ok    [WORDS];
   bit        tag_ok     [WORDS];
   bit [14:0] live_blocks;
   bit [31:0] grant_total;

   alloc_rsp_type    pending_rsp [$];
   logic [31:0]      grant_pool [$];
   alloc_rsp_type    want_rsp;
   stim_row_type     dir_rows [21];
   heap_setting_type settings [6];
   bit               steady = 1'b0;
   int               ready_hold = 0;
   int               idle_cycles = 0;
   int               mismatch_cnt = 0;
   int               n_req = 0, n_grant = 0, n_exhaust = 0, n_badcls = 0, n_free = 0;
   int               n_settings = 0;

   segregated_free_list_allocator_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_size_class       (req_size_class),
      .req_block_address    (req_block_address),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_granted_address  (rsp_granted_address),
      .rsp_status           (rsp_status),
      .rsp_class_free_count (rsp_class_free_count),
      .rsp_live_count       (rsp_live_count),
      .rsp_total_count      (rsp_total_count),
      .rsp_free_bytes       (rsp_free_bytes),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int heap_slot(input logic [31:0] a);
      logic [31:0] off;
      off = a - cfg_base;
      return int'((off >> 2) % WORDS);
   endfunction

   task automatic allocator_step(input alloc_req_type rq, output alloc_rsp_type rs);
      logic [32:0] blk_bytes;
      bit [3:0]    tag;
      int          s;
      bit          granted_ok;
      rs = '0;
      granted_ok = 1'b0;
      case (rq.func)
         sfla_pkg::FUNC_ALLOC: begin
            if (rq.cls >= NCLASS) begin
               rs.status = sfla_pkg::STATUS_BAD_CLASS;
            end else begin
               if (class_len[rq.cls] != 0) begin
                  rs.granted = class_head[rq.cls];
                  class_head[rq.cls] = link_mem[heap_slot(rs.granted)];
                  class_len[rq.cls] = class_len[rq.cls] - 1'b1;
                  granted_ok = 1'b1;
               end else begin
                  blk_bytes = (33'd1 << (rq.cls + sfla_pkg::MIN_POW_DEF))
                              + sfla_pkg::HEADER_BYTES_DEF;
                  if ({1'b0, bump} + blk_bytes <= {1'b0, cfg_limit}) begin
                     rs.granted = bump;
                     bump = bump + blk_bytes[31:0];
                     granted_ok = 1'b1;
                  end else begin
                     rs.status = sfla_pkg::STATUS_EXHAUSTED;
                  end
               end
               if (granted_ok) begin
                  s = heap_slot(rs.granted);
                  tag_mem[s] = rq.cls;
                  tag_ok[s] = 1'b1;
                  live_blocks = live_blocks + 1'b1;
                  grant_total = grant_total + 1'b1;
               end
               rs.fcount = class_len[rq.cls];
            end
         end
         sfla_pkg::FUNC_FREE: begin
            s = heap_slot(rq.addr);
            tag = tag_mem[s];
            if (tag >= NCLASS) begin
               rs.status = sfla_pkg::STATUS_BAD_CLASS;
            end else begin
               link_mem[s] = class_head[tag];
               link_ok[s] = 1'b1;
               class_head[tag] = rq.addr;
               class_len[tag] = class_len[tag] + 1'b1;
               live_blocks = live_blocks - 1'b1;
               rs.fcount = class_len[tag];
            end
         end
         default: begin
            if (rq.cls >= NCLASS) rs.status = sfla_pkg::STATUS_BAD_CLASS;
            else rs.fcount = class_len[rq.cls];
         end
      endcase
      rs.live = live_blocks;
      rs.total = grant_total;
      rs.free_bytes = cfg_limit - bump;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic build_request(output alloc_req_type rq);
      int          pick, sub, idx;
      int unsigned c;
      logic [31:0] a, rnd;
      rq.func = sfla_pkg::FUNC_QUERY;
      rq.cls  = 4'($urandom_range(0, 15));
      rq.addr = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         rq.func = sfla_pkg::FUNC_ALLOC;
         sub = $urandom_range(0, 19);
         if (sub < 12) c = $urandom_range(0, 4);
         else if (sub < 18) c = $urandom_range(5, 12);
         else c = $urandom_range(13, 15);
         rq.cls = 4'(c);
         // hold off a pop whose link was never written
         if (c < NCLASS && class_len[c] != 0 && !link_ok[heap_slot(class_head[c])])
            rq.func = sfla_pkg::FUNC_QUERY;
      end else if (pick < 85 && grant_pool.size() != 0) begin
         sub = $urandom_range(0, 9);
         idx = $urandom_range(0, grant_pool.size() - 1);
         a = grant_pool[idx];
         if (sub < 7) begin
            grant_pool.delete(idx);
         end else if (sub == 9) begin
            rnd = $urandom;
            a = {rnd[31:16], a[15:2], rnd[1:0]};
         end
         rq.addr = a;
         rq.func = tag_ok[heap_slot(a)] ? sfla_pkg::FUNC_FREE : sfla_pkg::FUNC_QUERY;
      end else if ($urandom_range(0, 3) == 0) begin
         rq.func = FUNC_SPARE;
      end
   endtask

   task automatic issue_request(input alloc_req_type rq, input bit typed,
                                input alloc_rsp_type typed_rsp);
      int            gap;
      alloc_rsp_type rs;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= rq.func;
      req_size_class    <= rq.cls;
      req_block_address <= rq.addr;
      do @(posedge clock); while (!req_ready);
      allocator_step(rq, rs);
      n_req++;
      if (rq.func == sfla_pkg::FUNC_FREE) n_free++;
      if (rq.func == sfla_pkg::FUNC_ALLOC && rs.status == sfla_pkg::STATUS_OK) begin
         n_grant++;
         grant_pool.push_back(rs.granted);
      end
      if (rs.status == sfla_pkg::STATUS_EXHAUSTED) n_exhaust++;
      if (rs.status == sfla_pkg::STATUS_BAD_CLASS) n_badcls++;
      pending_rsp.push_back(typed ? typed_rsp : rs);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("tb: mismatch on %s: got %h want %h", what, got, want);
      mismatch_cnt++;
   endtask

   task automatic csr_write(input logic reg_sel, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == sfla_pkg::REG_HEAP_BASE) begin
         cfg_base = value;
         bump = value;
      end else begin
         cfg_limit = value;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic reg_sel, input logic [31:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {reg_sel, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         note_mismatch(reg_sel == sfla_pkg::REG_HEAP_BASE ? "heap_base" : "heap_limit",
                       csr_prdata, want);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (steady) begin
         rsp_ready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 99) < 65) begin
         rsp_ready <= 1'b1;
         ready_hold <= $urandom_range(0, 15);
      end else begin
         rsp_ready <= 1'b0;
         ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            note_mismatch("unexpected response", rsp_granted_address, '0);
         end else begin
            want_rsp = pending_rsp.pop_front();
            if (rsp_granted_address !== want_rsp.granted)
               note_mismatch("granted_address", rsp_granted_address, want_rsp.granted);
            if (rsp_status !== want_rsp.status)
               note_mismatch("status", rsp_status, want_rsp.status);
            if (rsp_class_free_count !== want_rsp.fcount)
               note_mismatch("class_free_count", rsp_class_free_count, want_rsp.fcount);
            if (rsp_live_count !== want_rsp.live)
               note_mismatch("live_count", rsp_live_count, want_rsp.live);
            if (rsp_total_count !== want_rsp.total)
               note_mismatch("total_count", rsp_total_count, want_rsp.total);
            if (rsp_free_bytes !== want_rsp.free_bytes)
               note_mismatch("free_bytes", rsp_free_bytes, want_rsp.free_bytes);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("tb: stalled for %0d cycles", IDLE_LIMIT);
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      alloc_req_type rq;
      dir_rows = '{
         '{'{sfla_pkg::FUNC_QUERY, 4'd0, 32'h0}, 1'b1,
           '{32'h0, sfla_pkg::STATUS_OK, 15'd0, 15'd0, 32'h0, 32'h0001_0000}},
         '{'{sfla_pkg::FUNC_ALLOC, 4'd15, 32'hFFFF_FFFF}, 1'b1,
           '{32'h0, sfla_pkg::STATUS_BAD_CLASS, 15'd0, 15'd0, 32'h0, 32'h0001_0000}},
         '{'{sfla_pkg::FUNC_QUERY, 4'd13, 32'h0}, 1'b1,
           '{32'h0, sfla_pkg::STATUS_BAD_CLASS, 15'd0, 15'd0, 32'h0, 32'h0001_0000}},
         '{'{FUNC_SPARE, 4'd5, 32'h0}, 1'b1,
           '{32'h0, sfla_pkg::STATUS_OK, 15'd0, 15'd0, 32'h0, 32'h0001_0000}},
         '{'{sfla_pkg::FUNC_ALLOC, 4'd12, 32'h0}, 1'b1,
           '{32'h0, sfla_pkg::STATUS_EXHAUSTED, 15'd0, 15'd0, 32'h0, 32'h0001_0000}},
         '{'{sfla_pkg::FUNC_ALLOC, 4'd0, 32'h0}, 1'b1,
           '{32'h0, sfla_pkg::STATUS_OK, 15'd0, 15'd1, 32'h1, 32'h0000_FFE8}},
         '{'{sfla_pkg::FUNC_ALLOC, 4'd11, 32'h0}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_FREE,  4'd0, 32'h0}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_ALLOC, 4'd0, 32'h0}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_FREE,  4'd0, 32'h18}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_FREE,  4'd0, 32'h18}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_ALLOC, 4'd11, 32'h0}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_ALLOC, 4'd11, 32'h0}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_FREE,  4'd0, 32'h0}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_FREE,  4'd0, 32'h0}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_FREE,  4'd0, 32'h0}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_FREE,  4'd0, 32'hFFFF_0003}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_ALLOC, 4'd0, 32'h0}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_ALLOC, 4'd1, 32'h0}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_QUERY, 4'd12, 32'h0}, 1'b0, '0},
         '{'{sfla_pkg::FUNC_QUERY, 4'd15, 32'h0}, 1'b0, '0}
      };
      settings = '{
         '{32'h0000_1000, 32'h0000_3000, 200, 1'b0},
         '{32'hFFFF_0000, 32'hFFFF_FFFF, 180, 1'b0},
         '{32'h0000_0000, 32'h0000_0000,  60, 1'b1},
         '{32'hFFFF_FFFC, 32'h0000_0010,  60, 1'b0},
         '{32'h8000_0000, 32'h8002_0000, 220, 1'b0},
         '{32'h0000_0000, 32'h0001_0000, 160, 1'b1}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      csr_check(sfla_pkg::REG_HEAP_BASE, sfla_pkg::HEAP_BASE_RESET);
      csr_check(sfla_pkg::REG_HEAP_LIMIT, sfla_pkg::HEAP_LIMIT_RESET);

      foreach (dir_rows[i]) issue_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

      foreach (settings[p]) begin
         wait_drained();
         steady <= settings[p].steady;
         csr_write(sfla_pkg::REG_HEAP_BASE, settings[p].base);
         csr_write(sfla_pkg::REG_HEAP_LIMIT, settings[p].limit);
         csr_check(sfla_pkg::REG_HEAP_BASE, cfg_base);
         csr_check(sfla_pkg::REG_HEAP_LIMIT, cfg_limit);
         n_settings++;
         repeat (settings[p].items) begin
            build_request(rq);
            issue_request(rq, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("tb: %0d requests over %0d heap windows, %0d frees", n_req, n_settings, n_free);
      $display("tb: %0d grants, %0d exhausted, %0d bad class, %0d mismatches",
               n_grant, n_exhaust, n_badcls, mismatch_cnt);
      if (mismatch_cnt == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
